/* rtl/mac_byte_counter_table_assert.svh */
// Assertion macros shared by the byte counter table modules
`ifndef MAC_BYTE_COUNTER_TABLE_ASSERT_SVH
`define MAC_BYTE_COUNTER_TABLE_ASSERT_SVH
`ifndef SYNTH
`define MBCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define MBCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MBCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MBCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/mbct_pkg.sv */
// Shared types and constants for the MAC byte counter table
`default_nettype none
package mbct_pkg;

  localparam int MAC_W   = 48;
  localparam int TOTAL_W = 32;
  localparam int BYTES_W = 16;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic accept;
    logic rd_index;
    logic search;
    logic load_read;
    logic commit_hit;
    logic commit_new;
  } mbct_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss_end;
  } mbct_status_t;

endpackage
`default_nettype wire

/* rtl/mbct_ram.sv */
// Generic single write port, single read port RAM with registered read
`default_nettype none
module mbct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/mbct_datapath.sv */
// Datapath: key and total memories, search address, entry count and result registers
`default_nettype none
`include "mac_byte_counter_table_assert.svh"
module mbct_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mbct_pkg::mbct_cmd_t         cmd_i,
  output mbct_pkg::mbct_status_t           status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_data_i,
  input  wire logic [mbct_pkg::MAC_W-1:0]   transmitter_mac_i,
  input  wire logic [mbct_pkg::MAC_W-1:0]   receiver_mac_i,
  input  wire logic [mbct_pkg::BYTES_W-1:0] packet_bytes_i,
  input  wire logic [mbct_pkg::INDEX_W-1:0] read_index_i,
  output logic      [mbct_pkg::MAC_W-1:0]   entry_key_o,
  output logic      [mbct_pkg::TOTAL_W-1:0] entry_total_o,
  output logic                             entry_valid_o,
  output logic      [mbct_pkg::COUNT_W-1:0] entry_count_o,
  output logic                             table_full_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > mbct_pkg::INDEX_W) ? CW : mbct_pkg::INDEX_W;

  logic                          key_is_receiver_q;
  logic [mbct_pkg::MAC_W-1:0]    key_q;
  logic [mbct_pkg::BYTES_W-1:0]  size_q;
  logic [mbct_pkg::INDEX_W-1:0]  ridx_q;
  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 addr_q;
  logic                          cmp_vld_q;
  logic [AW-1:0]                 cmp_idx_q;

  logic [mbct_pkg::MAC_W-1:0]    res_key_q;
  logic [mbct_pkg::TOTAL_W-1:0]  res_total_q;
  logic                          res_valid_q;
  logic [mbct_pkg::COUNT_W-1:0]  res_count_q;
  logic                          res_full_q;

  logic [AW-1:0]                 rd_addr;
  logic [mbct_pkg::MAC_W-1:0]    rd_key;
  logic [mbct_pkg::TOTAL_W-1:0]  rd_total;
  logic                          issue;
  logic                          tbl_full;
  logic                          idx_used;
  logic [mbct_pkg::TOTAL_W:0]    sum_wide;
  logic [mbct_pkg::TOTAL_W-1:0]  sum_sat;
  logic [mbct_pkg::TOTAL_W-1:0]  size_ext;
  logic                          key_we;
  logic                          tot_we;
  logic [AW-1:0]                 tot_waddr;
  logic [mbct_pkg::TOTAL_W-1:0]  tot_wdata;
  logic [CW-1:0]                 count_inc;

  assign rd_addr   = cmd_i.rd_index ? AW'(ridx_q) : addr_q[AW-1:0];
  assign issue     = cmd_i.search && (addr_q < count_q);
  assign tbl_full  = (count_q == CW'(TABLE_DEPTH));
  assign idx_used  = (IW'(ridx_q) < IW'(count_q));
  assign size_ext  = mbct_pkg::TOTAL_W'(size_q);
  assign sum_wide  = {1'b0, rd_total} + {1'b0, size_ext};
  assign sum_sat   = sum_wide[mbct_pkg::TOTAL_W] ? '1 : sum_wide[mbct_pkg::TOTAL_W-1:0];
  assign count_inc = count_q + CW'(1);

  assign key_we    = cmd_i.commit_new && !tbl_full;
  assign tot_we    = cmd_i.commit_hit || key_we;
  assign tot_waddr = cmd_i.commit_hit ? cmp_idx_q : count_q[AW-1:0];
  assign tot_wdata = cmd_i.commit_hit ? sum_sat : size_ext;

  assign status_o.hit      = cmp_vld_q && (rd_key == key_q);
  assign status_o.miss_end = !cmp_vld_q && !(addr_q < count_q);

  mbct_ram #(
    .WIDTH(mbct_pkg::MAC_W),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(key_q),
    .raddr_i(rd_addr),
    .rdata_o(rd_key)
  );

  mbct_ram #(
    .WIDTH(mbct_pkg::TOTAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_total_ram (
    .clk_i  (clk_i),
    .we_i   (tot_we),
    .waddr_i(tot_waddr),
    .wdata_i(tot_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rd_total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_is_receiver_q <= 1'b0;
      count_q           <= '0;
      addr_q            <= '0;
      cmp_vld_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_is_receiver_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        addr_q    <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.search) begin
        cmp_vld_q <= issue;
        if (issue) begin
          addr_q <= addr_q + CW'(1);
        end
      end
      if (key_we) begin
        count_q <= count_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q  <= key_is_receiver_q ? receiver_mac_i : transmitter_mac_i;
      size_q <= packet_bytes_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.search) begin
      cmp_idx_q <= addr_q[AW-1:0];
    end
    if (cmd_i.load_read) begin
      res_key_q   <= idx_used ? rd_key : '0;
      res_total_q <= idx_used ? rd_total : '0;
      res_valid_q <= idx_used;
      res_count_q <= mbct_pkg::COUNT_W'(count_q);
      res_full_q  <= 1'b0;
    end else if (cmd_i.commit_hit) begin
      res_key_q   <= key_q;
      res_total_q <= sum_sat;
      res_valid_q <= 1'b1;
      res_count_q <= mbct_pkg::COUNT_W'(count_q);
      res_full_q  <= 1'b0;
    end else if (cmd_i.commit_new) begin
      res_key_q   <= key_q;
      res_total_q <= tbl_full ? '0 : size_ext;
      res_valid_q <= !tbl_full;
      res_count_q <= tbl_full ? mbct_pkg::COUNT_W'(count_q) : mbct_pkg::COUNT_W'(count_inc);
      res_full_q  <= tbl_full;
    end
  end

  assign entry_key_o   = res_key_q;
  assign entry_total_o = res_total_q;
  assign entry_valid_o = res_valid_q;
  assign entry_count_o = res_count_q;
  assign table_full_o  = res_full_q;

  `MBCT_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(TABLE_DEPTH), "count over depth")
  `MBCT_ASSERT_NXT(a_count_incr, clk_i, rst_ni, key_we, count_q == $past(count_q) + CW'(1), "count step")
  `MBCT_ASSERT_NXT(a_full_hold, clk_i, rst_ni, cmd_i.commit_new && tbl_full, res_full_q && !res_valid_q, "full drop")

endmodule
`default_nettype wire

/* rtl/mbct_ctrl.sv */
// Controller: sequences reads, searches and commits of table requests
`default_nettype none
`include "mac_byte_counter_table_assert.svh"
module mbct_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire logic                   op_i,
  output logic                        busy,
  output logic                        done_o,
  output mbct_pkg::mbct_cmd_t         cmd_o,
  input  wire mbct_pkg::mbct_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_SEARCH
  } state_e;

  state_e     state_q;
  logic       done_q;
  logic       accept;
  logic       finish;
  logic [2:0] commit_vec;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign accept = start && !busy;
  assign finish = status_i.hit || status_i.miss_end;

  assign cmd_o.accept     = accept;
  assign cmd_o.rd_index   = (state_q == ST_RD_ADDR);
  assign cmd_o.load_read  = (state_q == ST_RD_DATA);
  assign cmd_o.search     = (state_q == ST_SEARCH);
  assign cmd_o.commit_hit = (state_q == ST_SEARCH) && status_i.hit;
  assign cmd_o.commit_new = (state_q == ST_SEARCH) && !status_i.hit && status_i.miss_end;

  assign commit_vec = {cmd_o.load_read, cmd_o.commit_hit, cmd_o.commit_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (op_i == mbct_pkg::OP_READ) ? ST_RD_ADDR : ST_SEARCH;
          end
        end
        ST_RD_ADDR: begin
          state_q <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        ST_SEARCH: begin
          if (finish) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MBCT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy, "accepted request not busy")
  `MBCT_ASSERT_IMP(a_done_after_work, clk_i, rst_ni, done_q, $past(busy), "result without work")
  `MBCT_ASSERT_IMP(a_one_commit, clk_i, rst_ni, 1'b1, $onehot0(commit_vec), "commit overlap")

endmodule
`default_nettype wire

/* rtl/mac_byte_counter_table.sv */
// A read request addresses both memories at the latched index, then loads its result
// and strobes done_o. A record request makes one key compare per cycle through the key
// memory read port, from entry 0 upward, and strobes on the first match, or after the
// last used entry for a new or dropped key, or without a compare on an empty table.
// The next request is taken in the cycle of the strobe; the receiver cannot stall results.
// Reset clears control, entry count and key select; entries above the count are unread.
`default_nettype none
module mac_byte_counter_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        op_i,
  input  wire logic [mbct_pkg::MAC_W-1:0]   transmitter_mac_i,
  input  wire logic [mbct_pkg::MAC_W-1:0]   receiver_mac_i,
  input  wire logic [mbct_pkg::BYTES_W-1:0] packet_bytes_i,
  input  wire logic [mbct_pkg::INDEX_W-1:0] read_index_i,
  output logic                             done_o,
  output logic      [mbct_pkg::MAC_W-1:0]   entry_key_o,
  output logic      [mbct_pkg::TOTAL_W-1:0] entry_total_o,
  output logic                             entry_valid_o,
  output logic      [mbct_pkg::COUNT_W-1:0] entry_count_o,
  output logic                             table_full_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_data_i
);

  mbct_pkg::mbct_cmd_t    cmd;
  mbct_pkg::mbct_status_t status;

  assign cfg_ready_o = 1'b1;

  mbct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .op_i    (op_i),
    .busy    (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .status_i(status)
  );

  mbct_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .transmitter_mac_i(transmitter_mac_i),
    .receiver_mac_i   (receiver_mac_i),
    .packet_bytes_i   (packet_bytes_i),
    .read_index_i     (read_index_i),
    .entry_key_o      (entry_key_o),
    .entry_total_o    (entry_total_o),
    .entry_valid_o    (entry_valid_o),
    .entry_count_o    (entry_count_o),
    .table_full_o     (table_full_o)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for mac_byte_counter_table: directed, large-total and random request tests
`timescale 1ns / 1ps
module tb_top;

  localparam int TABLE_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 580;
  localparam int CYCLE_LIMIT  = 12_000_000;

  typedef struct packed {
    logic [mbct_pkg::MAC_W-1:0]   key;
    logic [mbct_pkg::TOTAL_W-1:0] total;
    logic                         valid;
    logic [mbct_pkg::COUNT_W-1:0] count;
    logic                         full;
  } table_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         op_i = mbct_pkg::OP_RECORD;
  logic [mbct_pkg::MAC_W-1:0]   transmitter_mac_i = '0;
  logic [mbct_pkg::MAC_W-1:0]   receiver_mac_i = '0;
  logic [mbct_pkg::BYTES_W-1:0] packet_bytes_i = '0;
  logic [mbct_pkg::INDEX_W-1:0] read_index_i = '0;
  logic                         done_o;
  logic [mbct_pkg::MAC_W-1:0]   entry_key_o;
  logic [mbct_pkg::TOTAL_W-1:0] entry_total_o;
  logic                         entry_valid_o;
  logic [mbct_pkg::COUNT_W-1:0] entry_count_o;
  logic                         table_full_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic                         cfg_data_i = 1'b0;

  logic [mbct_pkg::MAC_W-1:0]   model_keys [TABLE_DEPTH];
  logic [mbct_pkg::TOTAL_W-1:0] model_totals [TABLE_DEPTH];
  int                           model_count = 0;
  logic                         model_key_rx = 1'b0;

  table_result_t      pending_results [$];
  bit                 quiet = 1'b0;
  bit                 rx_key_used = 1'b0;
  int                 errors = 0;
  int                 results_checked = 0;
  int                 record_requests = 0;
  int                 read_requests = 0;
  int                 saturated_hits = 0;
  int                 full_drops = 0;
  longint             cycle_count = 0;

  mac_byte_counter_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .op_i              (op_i),
    .transmitter_mac_i (transmitter_mac_i),
    .receiver_mac_i    (receiver_mac_i),
    .packet_bytes_i    (packet_bytes_i),
    .read_index_i      (read_index_i),
    .done_o            (done_o),
    .entry_key_o       (entry_key_o),
    .entry_total_o     (entry_total_o),
    .entry_valid_o     (entry_valid_o),
    .entry_count_o     (entry_count_o),
    .table_full_o      (table_full_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [mbct_pkg::MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic table_result_t predict_table_result(
    input logic                         op,
    input logic [mbct_pkg::MAC_W-1:0]   tx,
    input logic [mbct_pkg::MAC_W-1:0]   rx,
    input logic [mbct_pkg::BYTES_W-1:0] nbytes,
    input logic [mbct_pkg::INDEX_W-1:0] idx
  );
    table_result_t                r;
    logic [mbct_pkg::MAC_W-1:0]   key;
    logic [mbct_pkg::TOTAL_W:0]   sum;
    int                           hit;
    r = '0;
    if (op == mbct_pkg::OP_READ) begin
      read_requests++;
      if (idx < model_count) begin
        r.key   = model_keys[idx];
        r.total = model_totals[idx];
        r.valid = 1'b1;
      end
    end else begin
      record_requests++;
      key = model_key_rx ? rx : tx;
      hit = -1;
      for (int j = 0; j < model_count && hit < 0; j++) begin
        if (model_keys[j] == key) hit = j;
      end
      r.key = key;
      if (hit >= 0) begin
        sum = model_totals[hit] + nbytes;
        if (sum[mbct_pkg::TOTAL_W]) begin
          model_totals[hit] = '1;
          saturated_hits++;
        end else begin
          model_totals[hit] = sum[mbct_pkg::TOTAL_W-1:0];
        end
        r.total = model_totals[hit];
        r.valid = 1'b1;
      end else if (model_count < TABLE_DEPTH) begin
        model_keys[model_count]   = key;
        model_totals[model_count] = mbct_pkg::TOTAL_W'(nbytes);
        model_count++;
        r.total = mbct_pkg::TOTAL_W'(nbytes);
        r.valid = 1'b1;
      end else begin
        r.full = 1'b1;
        full_drops++;
      end
    end
    r.count = mbct_pkg::COUNT_W'(model_count);
    return r;
  endfunction

  task automatic send_request(
    input logic                         op,
    input logic [mbct_pkg::MAC_W-1:0]   tx,
    input logic [mbct_pkg::MAC_W-1:0]   rx,
    input logic [mbct_pkg::BYTES_W-1:0] nbytes,
    input logic [mbct_pkg::INDEX_W-1:0] idx
  );
    start             <= 1'b1;
    op_i              <= op;
    transmitter_mac_i <= tx;
    receiver_mac_i    <= rx;
    packet_bytes_i    <= nbytes;
    read_index_i      <= idx;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_table_result(op, tx, rx, nbytes, idx));
    if (!quiet && $urandom_range(99) < 27) begin
      start             <= 1'b0;
      op_i              <= 1'($urandom);
      transmitter_mac_i <= random_mac();
      receiver_mac_i    <= random_mac();
      packet_bytes_i    <= 16'($urandom);
      read_index_i      <= 10'($urandom);
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_record(input logic [mbct_pkg::MAC_W-1:0] tx,
                             input logic [mbct_pkg::MAC_W-1:0] rx,
                             input logic [mbct_pkg::BYTES_W-1:0] nbytes);
    send_request(mbct_pkg::OP_RECORD, tx, rx, nbytes, 10'($urandom));
  endtask

  task automatic send_read(input logic [mbct_pkg::INDEX_W-1:0] idx);
    send_request(mbct_pkg::OP_READ, random_mac(), random_mac(), 16'($urandom), idx);
  endtask

  task automatic write_key_select(input logic key_rx);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= key_rx;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    model_key_rx = key_rx;
    if (key_rx) rx_key_used = 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    write_key_select(1'b0);
    send_read('0);
    send_read('1);
    send_record('0, '1, '0);
    send_record('1, '0, '1);
    send_record('0, random_mac(), '1);
    send_record('1, random_mac(), 16'd1);
    send_record(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA);
    send_record(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5555);
    for (int i = 0; i < 5; i++) send_read(mbct_pkg::INDEX_W'(i));
    send_read(10'h2AA);
    send_read(10'h155);
    write_key_select(1'b1);
    send_record(random_mac(), 48'hAAAA_AAAA_AAAA, 16'h1234);
    send_record(random_mac(), random_mac(), 16'h00FF);
    send_record(random_mac(), '0, 16'd7);
    send_read(10'd4);
    write_key_select(1'b0);
  endtask

  task automatic test_large_totals();
    repeat (4) send_record(model_keys[0], model_keys[0], '1);
    send_record(model_keys[0], model_keys[0], '0);
    send_read('0);
  endtask

  task automatic test_random_traffic();
    logic [mbct_pkg::MAC_W-1:0]   key_pool [32];
    logic [mbct_pkg::MAC_W-1:0]   tx;
    logic [mbct_pkg::MAC_W-1:0]   rx;
    logic [mbct_pkg::BYTES_W-1:0] nbytes;
    logic [mbct_pkg::INDEX_W-1:0] idx;
    logic                         op;
    for (int i = 0; i < 32; i++) key_pool[i] = random_mac();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 116 == 115) write_key_select(1'((n / 116) % 2 == 0));
      quiet = (n >= 250 && n < 360);
      op = ($urandom_range(99) < 25) ? mbct_pkg::OP_READ : mbct_pkg::OP_RECORD;
      tx = ($urandom_range(99) < 70) ? key_pool[$urandom_range(31)] : random_mac();
      rx = ($urandom_range(99) < 70) ? key_pool[$urandom_range(31)] : random_mac();
      case ($urandom_range(9))
        0: nbytes = '0;
        1: nbytes = '1;
        default: nbytes = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0: idx = 10'($urandom);
        1: idx = mbct_pkg::INDEX_W'(model_count);
        default: idx = mbct_pkg::INDEX_W'($urandom_range(model_count > 0 ? model_count - 1 : 0));
      endcase
      send_request(op, tx, rx, nbytes, idx);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin : result_checker
    table_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request pending");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (entry_key_o !== exp_r.key) begin
          $error("entry_key: expected %h, got %h", exp_r.key, entry_key_o);
          errors++;
        end
        if (entry_total_o !== exp_r.total) begin
          $error("entry_total: expected %h, got %h", exp_r.total, entry_total_o);
          errors++;
        end
        if (entry_valid_o !== exp_r.valid) begin
          $error("entry_valid: expected %b, got %b", exp_r.valid, entry_valid_o);
          errors++;
        end
        if (entry_count_o !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, entry_count_o);
          errors++;
        end
        if (table_full_o !== exp_r.full) begin
          $error("table_full: expected %b, got %b", exp_r.full, table_full_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_large_totals();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    $display("Checked %0d results from %0d record and %0d read requests in %0d cycles.",
             results_checked, record_requests, read_requests, cycle_count);
    $display("Table held %0d keys, %0d saturated sums, %0d dropped keys, rx key used: %0b.",
             model_count, saturated_hits, full_drops, rx_key_used);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* mac_byte_counter_table.f */
+incdir+rtl
rtl/mbct_pkg.sv
rtl/mbct_ram.sv
rtl/mbct_datapath.sv
rtl/mbct_ctrl.sv
rtl/mac_byte_counter_table.sv
tb/tb_top.sv
